// ----- hw/rtl/lighting_command_frame_builder_defines.svh -----
// ----------------------------------------------------------------------------
// Lighting command frame builder - assertion macros
// Shared property shorthands for the builder's internal checks.
// ----------------------------------------------------------------------------
`ifndef LIGHTING_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define LIGHTING_COMMAND_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCFB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCFB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lcfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lighting command frame builder - package
// Frame constants, byte positions, the command descriptor and helpers.
// ----------------------------------------------------------------------------
package lcfb_pkg;

    localparam logic [7:0] FRAME_START     = 8'h68;
    localparam logic [7:0] FRAME_END       = 8'h16;
    localparam logic [7:0] CTRL_QUERY      = 8'h21;
    localparam logic [7:0] CTRL_SWITCH     = 8'h20;
    localparam logic [7:0] SWITCH_DATA_LEN = 8'h09;
    localparam logic [7:0] CHANNEL_DEFAULT = 8'h02;
    localparam logic [7:0] ASCII_ZERO      = 8'h30;

    // Opcodes carried in the input word's side band.
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_SWITCH = 1'b1;

    // Configuration register indexes.
    localparam logic REG_ADDR_FIRST = 1'b0;
    localparam logic REG_ADDR_LAST  = 1'b1;

    // Byte positions within a frame.
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_START      = 5'd0;
    localparam logic [POS_W-1:0] POS_ADDR0      = 5'd1;
    localparam logic [POS_W-1:0] POS_ADDR1      = 5'd2;
    localparam logic [POS_W-1:0] POS_ADDR2      = 5'd3;
    localparam logic [POS_W-1:0] POS_ADDR3      = 5'd4;
    localparam logic [POS_W-1:0] POS_ADDR4      = 5'd5;
    localparam logic [POS_W-1:0] POS_ADDR5      = 5'd6;
    localparam logic [POS_W-1:0] POS_SEQ_LO     = 5'd7;
    localparam logic [POS_W-1:0] POS_SEQ_HI     = 5'd8;
    localparam logic [POS_W-1:0] POS_START2     = 5'd9;
    localparam logic [POS_W-1:0] POS_CTRL       = 5'd10;
    localparam logic [POS_W-1:0] POS_LEN_LO     = 5'd11;
    localparam logic [POS_W-1:0] POS_LEN_HI     = 5'd12;
    localparam logic [POS_W-1:0] POS_CHAN_FIRST = 5'd13;
    localparam logic [POS_W-1:0] POS_CHAN_LAST  = 5'd20;
    localparam logic [POS_W-1:0] POS_CLR        = 5'd21;
    localparam logic [POS_W-1:0] POS_QUERY_CHK  = 5'd13;
    localparam logic [POS_W-1:0] POS_QUERY_END  = 5'd14;
    localparam logic [POS_W-1:0] POS_SWITCH_CHK = 5'd22;
    localparam logic [POS_W-1:0] POS_SWITCH_END = 5'd23;
    // Channel byte n (1..8) sits at position CHAN_BASE + n.
    localparam logic [POS_W-1:0] CHAN_BASE      = 5'd12;

    // Command queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        is_switch;
        logic [3:0]  channel;
        logic        switch_on;
        logic        clear_error;
        logic [15:0] seq;
    } cmd_t;

    // Two ASCII digit characters to one address byte, wrapping modulo 256.
    function automatic logic [7:0] addr_byte(input logic [7:0] hi_char,
                                             input logic [7:0] lo_char);
        logic [7:0] hi_digit;
        logic [7:0] lo_digit;
        hi_digit = hi_char - ASCII_ZERO;
        lo_digit = lo_char - ASCII_ZERO;
        return {hi_digit[3:0], 4'b0000} + lo_digit;
    endfunction

endpackage

// ----- hw/rtl/lcfb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lighting command frame builder - front end
// Accepts command words, classifies them and tags each with its sequence
// number before handing it to the command queue.
// ----------------------------------------------------------------------------
module lcfb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [3:0] channel, [4] switch_on, [5] clear_error
    input  logic                s_tuser,   // [0] opcode
    input  logic                q_full,
    output logic                q_push,
    output lcfb_pkg::cmd_t      q_cmd
);
    import lcfb_pkg::*;

    logic [15:0] seq_reg;
    logic [15:0] seq_next;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    always_comb begin
        q_cmd.is_switch   = (s_tuser == OP_SWITCH);
        q_cmd.channel     = s_tdata[3:0];
        q_cmd.switch_on   = s_tdata[4];
        q_cmd.clear_error = s_tdata[5];
        q_cmd.seq         = seq_reg;
    end

    // The sequence number belongs to the order in which commands arrive.
    always_comb begin
        seq_next = seq_reg;
        if (accept) begin
            seq_next = seq_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= 16'd0;
        end else begin
            seq_reg <= seq_next;
        end
    end

endmodule

// ----- hw/rtl/lcfb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lighting command frame builder - command queue
// Short FIFO of command descriptors between the front and back ends.
// ----------------------------------------------------------------------------
`include "lighting_command_frame_builder_defines.svh"

module lcfb_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lcfb_pkg::cmd_t      push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output lcfb_pkg::cmd_t      head_cmd
);
    import lcfb_pkg::*;

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `LCFB_ASSERT_NOW(a_no_push_when_full, aclk, aresetn, push, !full, "push into a full command queue")
    `LCFB_ASSERT_NOW(a_no_pop_when_empty, aclk, aresetn, pop, head_valid, "pop from an empty command queue")
    `LCFB_ASSERT_NEXT(a_count_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1), "queue count did not grow on push")

endmodule

// ----- hw/rtl/lcfb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lighting command frame builder - back end
// Walks the command at the queue head byte by byte, forms each frame byte,
// keeps the running checksum and drives the registered output word.
// ----------------------------------------------------------------------------
`include "lighting_command_frame_builder_defines.svh"

module lcfb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  lcfb_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic [47:0]         addr_first,
    input  logic [47:0]         addr_last,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] frame_byte
    output logic                m_tlast    // last_byte
);
    import lcfb_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic [7:0]       m_tdata_next;
    logic             m_tlast_reg;
    logic             m_tlast_next;

    logic [95:0]      addr_chars;
    logic [7:0]       addr_bytes [6];
    logic             advance;
    logic             is_chk;
    logic             is_end;
    logic [POS_W-1:0] chan_sel;
    logic [7:0]       byte_val;

    assign addr_chars = {addr_first, addr_last};

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            addr_bytes[k] = addr_byte(addr_chars[95 - 16*k -: 8], addr_chars[87 - 16*k -: 8]);
        end
    end

    assign is_chk  = (pos_reg == (cmd.is_switch ? POS_SWITCH_CHK : POS_QUERY_CHK));
    assign is_end  = (pos_reg == (cmd.is_switch ? POS_SWITCH_END : POS_QUERY_END));
    assign advance = cmd_valid && (!m_tvalid_reg || m_tready);
    assign cmd_pop = advance && is_end;

    always_comb begin
        chan_sel = pos_reg - CHAN_BASE;
        byte_val = 8'h00;
        if (is_end) begin
            byte_val = FRAME_END;
        end else if (is_chk) begin
            byte_val = sum_reg;
        end else begin
            case (pos_reg)
                POS_START, POS_START2: byte_val = FRAME_START;
                POS_ADDR0:  byte_val = addr_bytes[0];
                POS_ADDR1:  byte_val = addr_bytes[1];
                POS_ADDR2:  byte_val = addr_bytes[2];
                POS_ADDR3:  byte_val = addr_bytes[3];
                POS_ADDR4:  byte_val = addr_bytes[4];
                POS_ADDR5:  byte_val = addr_bytes[5];
                POS_SEQ_LO: byte_val = cmd.seq[7:0];
                POS_SEQ_HI: byte_val = cmd.seq[15:8];
                POS_CTRL:   byte_val = cmd.is_switch ? CTRL_SWITCH : CTRL_QUERY;
                POS_LEN_LO: byte_val = cmd.is_switch ? SWITCH_DATA_LEN : 8'h00;
                POS_CLR:    byte_val = {7'd0, cmd.clear_error};
                default: begin
                    // Channel bytes; an out-of-range channel matches none of them.
                    if (pos_reg inside {[POS_CHAN_FIRST:POS_CHAN_LAST]}) begin
                        if ({1'b0, cmd.channel} == chan_sel) begin
                            byte_val = {7'd0, cmd.switch_on};
                        end else begin
                            byte_val = CHANNEL_DEFAULT;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (advance) begin
            pos_next      = is_end ? POS_START : pos_reg + POS_W'(1);
            sum_next      = (pos_reg == POS_START) ? byte_val : sum_reg + byte_val;
            m_tvalid_next = 1'b1;
            m_tdata_next  = byte_val;
            m_tlast_next  = is_end;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_START;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg     <= sum_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `LCFB_ASSERT_NOW(a_last_is_end_byte, aclk, aresetn, m_tvalid_reg && m_tlast_reg, m_tdata_reg == FRAME_END, "last word is not the end byte")
    `LCFB_ASSERT_NOW(a_head_held_mid_frame, aclk, aresetn, pos_reg != POS_START, cmd_valid, "command left the queue in mid-frame")
    `LCFB_ASSERT_NEXT(a_frame_restarts, aclk, aresetn, cmd_pop, pos_reg == POS_START, "byte position did not restart after a frame")

endmodule

// ----- hw/rtl/lighting_command_frame_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lighting command frame builder - top level
// Turns command words into request frames for a lighting controller.
// ----------------------------------------------------------------------------
// Each accepted command word yields one frame sent one byte per output word:
// a 15-byte status query (opcode 0) or a 24-byte switch command (opcode 1),
// with tlast on the closing 0x16. The byte sequencer in the back end emits
// one byte per clock while a command is queued and m_tready does not stall
// the output; the front end keeps taking command words into a
// two-entry queue while a frame is going out, so frames follow one another
// with no gap. The sequence number is stamped in arrival order and steps
// after every command. The address registers are read live while frames
// are formed, so write them only while the block is idle.
module lighting_command_frame_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] channel, [4] switch_on, [5] clear_error, [7:6] zero
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast    // last_byte
);
    import lcfb_pkg::*;

    logic [47:0] addr_first_reg;
    logic [47:0] addr_first_next;
    logic [47:0] addr_last_reg;
    logic [47:0] addr_last_next;

    logic        q_push;
    cmd_t        q_push_cmd;
    logic        q_full;
    logic        q_pop;
    logic        q_head_valid;
    cmd_t        q_head_cmd;

    always_comb begin
        addr_first_next = addr_first_reg;
        addr_last_next  = addr_last_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_ADDR_FIRST: addr_first_next = cfg_wdata;
                REG_ADDR_LAST:  addr_last_next  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_first_reg <= 48'd0;
            addr_last_reg  <= 48'd0;
        end else begin
            addr_first_reg <= addr_first_next;
            addr_last_reg  <= addr_last_next;
        end
    end

    lcfb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    lcfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    lcfb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (q_head_valid),
        .cmd        (q_head_cmd),
        .cmd_pop    (q_pop),
        .addr_first (addr_first_reg),
        .addr_last  (addr_last_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
